@@ hw/rtl/wm2d_pkg.sv @@
// Shared constants, register indexes and helpers of the two-dimensional window minimum core.
`default_nettype none
package wm2d_pkg;

	localparam int DefMaxCols    = 1024;
	localparam int DefMaxWinRows = 16;
	localparam int DefMaxWinCols = 16;
	localparam int DefSampleBits = 32;

	localparam int RowsLimit = 1024;
	localparam int RowW      = 10;
	localparam int CfgDataW  = 11;
	localparam int CfgIdxW   = 2;
	localparam int ClampW    = 13;

	localparam logic [CfgIdxW-1:0] CFG_IMAGE_COLS  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_IMAGE_ROWS  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_WINDOW_ROWS = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_WINDOW_COLS = 2'd3;

	typedef logic [ClampW-1:0] clamp_t;

	function automatic clamp_t clamp_reg(input logic [CfgDataW-1:0] v, input clamp_t top);
		clamp_t ext;
		ext = clamp_t'(v);
		if (ext == '0) begin
			return clamp_t'(1);
		end
		return (ext > top) ? top : ext;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/window_min_2d_core.sv @@
// Top level of the two-dimensional sliding window minimum core.
// Samples arrive in raster order; each yields the minimum over the window of up to window_rows
// rows and window_cols columns ending at that position, cut short at the top and left edges.
// One item is worked on at a time. An item is not accepted until the last one has gone to the
// output register, which may wait for that register to drain: the horizontal minimum steps
// through the row history one tap per cycle, the row minimum is written to the line store, and
// the vertical minimum reads one stored row minimum per cycle from the single line store RAM.
// A finished result waits in the output register while the next sample is taken. Register
// writes are taken only between items and win over a waiting sample. The line store needs no
// clearing pass after reset.
`default_nettype none
module window_min_2d_core #(
	parameter int MAX_COLS     = wm2d_pkg::DefMaxCols,
	parameter int MAX_WIN_ROWS = wm2d_pkg::DefMaxWinRows,
	parameter int MAX_WIN_COLS = wm2d_pkg::DefMaxWinCols,
	parameter int SAMPLE_BITS  = wm2d_pkg::DefSampleBits
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [wm2d_pkg::CfgIdxW-1:0]          cfg_index,
	input  wire logic [wm2d_pkg::CfgDataW-1:0]         cfg_data,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata, // sample
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic      [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata, // window_min
	output logic                                       m_tlast  // frame_end
);
	import wm2d_pkg::*;

	localparam int BUS_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int SLOT_W = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1;
	localparam int DEPTH  = MAX_WIN_ROWS * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int HK_W   = $clog2(MAX_WIN_COLS + 1);
	localparam int HI_W   = (MAX_WIN_COLS > 1) ? $clog2(MAX_WIN_COLS) : 1;
	localparam int VK_W   = $clog2(MAX_WIN_ROWS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HMIN = 3'd1;
	localparam logic [2:0] ST_WR   = 3'd2;
	localparam logic [2:0] ST_VRD  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [CfgDataW-1:0]    image_cols_q, image_rows_q, window_rows_q, window_cols_q;
	logic [2:0]             state_q;
	logic [COL_W-1:0]       col_q, lo_q;
	logic [RowW-1:0]        row_q;
	logic [SLOT_W-1:0]      slot_q, rd_slot_q, rd_slot_start;
	logic [SAMPLE_BITS-1:0] hist_q [MAX_WIN_COLS];
	logic [SAMPLE_BITS-1:0] acc_q, win_q, rdata;
	logic [HK_W-1:0]        hk_q, hn_q;
	logic [VK_W-1:0]        vk_q, avail_q;
	logic                   pend_q, m_valid_q, last_q;
	logic                   in_fire, rd_en, out_free, row_end, frame_end;
	clamp_t                 cols_c, rows_c, wr_c, wc_c, col_p1, row_p1, hn_c, avail_c;
	clamp_t                 lo_cut, lo_c;
	logic [ADDR_W-1:0]      waddr, raddr;

	assign cfg_ready = (state_q == ST_IDLE);
	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;

	assign cols_c = clamp_reg(image_cols_q, clamp_t'(MAX_COLS));
	assign rows_c = clamp_reg(image_rows_q, clamp_t'(RowsLimit));
	assign wr_c   = clamp_reg(window_rows_q, clamp_t'(MAX_WIN_ROWS));
	assign wc_c   = clamp_reg(window_cols_q, clamp_t'(MAX_WIN_COLS));
	assign col_p1 = clamp_t'(col_q) + clamp_t'(1);
	assign row_p1 = clamp_t'(row_q) + clamp_t'(1);
	assign lo_cut  = (col_p1 > wc_c) ? col_p1 - wc_c : '0;
	assign lo_c    = (clamp_t'(lo_q) > lo_cut) ? clamp_t'(lo_q) : lo_cut;
	assign hn_c    = col_p1 - lo_c;
	assign avail_c = (wr_c < row_p1) ? wr_c : row_p1;
	assign row_end   = (col_p1 >= cols_c);
	assign frame_end = row_end && (row_p1 >= rows_c);

	assign rd_slot_start = (slot_q == '0) ? SLOT_W'(MAX_WIN_ROWS - 1) : slot_q - SLOT_W'(1);
	assign rd_en = (state_q == ST_VRD) && (vk_q < avail_q);
	assign waddr = ADDR_W'(slot_q) * ADDR_W'(MAX_COLS) + ADDR_W'(col_q);
	assign raddr = ADDR_W'(rd_slot_q) * ADDR_W'(MAX_COLS) + ADDR_W'(col_q);

	wm2d_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (state_q == ST_WR),
		.waddr(waddr),
		.wdata(acc_q),
		.re   (rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_cols_q  <= CfgDataW'(MAX_COLS);
			image_rows_q  <= CfgDataW'(RowsLimit);
			window_rows_q <= CfgDataW'(1);
			window_cols_q <= CfgDataW'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_COLS:  image_cols_q  <= cfg_data;
				CFG_IMAGE_ROWS:  image_rows_q  <= cfg_data;
				CFG_WINDOW_ROWS: window_rows_q <= CfgDataW'(cfg_data[4:0]);
				CFG_WINDOW_COLS: window_cols_q <= CfgDataW'(cfg_data[4:0]);
				default:         image_cols_q  <= image_cols_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			hist_q[0] <= s_tdata[SAMPLE_BITS-1:0];
			for (int i = 1; i < MAX_WIN_COLS; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			col_q     <= '0;
			lo_q      <= '0;
			row_q     <= '0;
			slot_q    <= '0;
			rd_slot_q <= '0;
			hk_q      <= '0;
			hn_q      <= '0;
			vk_q      <= '0;
			avail_q   <= '0;
			pend_q    <= 1'b0;
			m_valid_q <= 1'b0;
			last_q    <= 1'b0;
			acc_q     <= '0;
			win_q     <= '0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						acc_q   <= s_tdata[SAMPLE_BITS-1:0];
						hk_q    <= HK_W'(1);
						hn_q    <= HK_W'(hn_c);
						lo_q    <= lo_c[COL_W-1:0];
						state_q <= ST_HMIN;
					end
				end
				ST_HMIN: begin
					if (hk_q < hn_q) begin
						if ($signed(hist_q[hk_q[HI_W-1:0]]) < $signed(acc_q)) begin
							acc_q <= hist_q[hk_q[HI_W-1:0]];
						end
						hk_q <= hk_q + HK_W'(1);
					end else begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					vk_q      <= VK_W'(1);
					avail_q   <= VK_W'(avail_c);
					rd_slot_q <= rd_slot_start;
					pend_q    <= 1'b0;
					state_q   <= ST_VRD;
				end
				ST_VRD: begin
					pend_q <= rd_en;
					if (rd_en) begin
						vk_q      <= vk_q + VK_W'(1);
						rd_slot_q <= (rd_slot_q == '0) ? SLOT_W'(MAX_WIN_ROWS - 1)
							: rd_slot_q - SLOT_W'(1);
					end
					if (pend_q && ($signed(rdata) < $signed(acc_q))) begin
						acc_q <= rdata;
					end
					if (!rd_en && !pend_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						win_q     <= acc_q;
						last_q    <= frame_end;
						state_q   <= ST_IDLE;
						if (row_end) begin
							col_q <= '0;
							lo_q  <= '0;
							if (frame_end) begin
								row_q  <= '0;
								slot_q <= '0;
							end else begin
								row_q  <= row_q + RowW'(1);
								slot_q <= (slot_q == SLOT_W'(MAX_WIN_ROWS - 1)) ? '0
									: slot_q + SLOT_W'(1);
							end
						end else begin
							col_q <= col_q + COL_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = BUS_W'(win_q);
	assign m_tlast  = last_q;

	a_pend_in_vrd: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == ST_VRD))
		else $error("line store read pending outside vertical pass");

	a_hmin_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HMIN) && $past(state_q == ST_HMIN) |-> $signed(acc_q) <= $signed($past(acc_q)))
		else $error("horizontal minimum grew");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) && last_q |-> (row_q == '0) && (col_q == '0) && (slot_q == '0))
		else $error("positions not cleared at frame end");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VRD) |-> (vk_q <= avail_q))
		else $error("vertical pass overran its row count");

endmodule
`default_nettype wire

@@ hw/rtl/wm2d_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module wm2d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire
